>>> hdl/ikc_pkg.sv
// shared types, constants and helpers for the integer kernel convolution block
`default_nettype none
package ikc_pkg;

	localparam int KSIZE_DEF      = 5;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int KMAX           = 5;
	localparam int DIM_W          = 11;
	localparam int CNT_W          = 10;
	localparam int ST_AW          = 13;
	localparam int CFG_AW         = 3;
	localparam int CFG_DW         = 40;
	localparam int FIFO_DEPTH     = 4;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ROW0   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_ROW1   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_ROW2   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_ROW3   = 3'd5;
	localparam logic [CFG_AW-1:0] REG_ROW4   = 3'd6;

	localparam logic [CFG_DW-1:0] ROW_RESET_LO = 40'h00_0001_0101;
	localparam logic [CFG_DW-1:0] ROW_RESET_HI = 40'h0;

	typedef logic [KMAX-1:0][CFG_DW-1:0] coeff_rows_t;

	// one output job handed from the front to the back
	typedef struct packed {
		logic [ST_AW-1:0] pos;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		logic             geo;
		logic             last;
		logic             latch;
	} job_t;

	// signed coefficient of kernel row u, column v
	function automatic logic signed [7:0] coef(input coeff_rows_t rows,
			input logic [2:0] u, input logic [2:0] v);
		logic [CFG_DW-1:0] r;
		r = rows[u];
		return $signed(r[v*8 +: 8]);
	endfunction

endpackage
`default_nettype wire

>>> hdl/integer_kernel_image_convolution_top.sv
// top level of the integer kernel image convolution block
//
//  port group  | kind              | moves
//  cfg_*       | write enable      | register index and 40-bit data
//  in_*        | valid / ready     | cmd and pixel_in word
//  out_*       | valid / ready     | out_row, out_col, pixel_out, border_pass, frame_last
//
// Border and zero-scale words pass ST_IDLE, ST_START, ST_PIX and ST_PIXW to the result.
// Interior words take KSIZE*KSIZE tap reads on the single history read port, a product
// drain and a restoring division at one quotient bit per cycle (21 bits).
// The first word of a frame also passes ST_SCALE and ST_SETSC for the scale latch.
// The front accepts words while the 4-deep job queue has room.
// No clearing pass after reset: history is written before read.
`default_nettype none
module integer_kernel_image_convolution_top
	import ikc_pkg::*;
#(
	parameter int KSIZE      = KSIZE_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              cmd,
	input  wire logic [7:0]        pixel_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [CNT_W-1:0]  out_row,
	output logic      [CNT_W-1:0]  out_col,
	output logic      [7:0]        pixel_out,
	output logic                   border_pass,
	output logic                   frame_last
);
	logic [DIM_W-1:0] width_q, height_q, eff_w, eff_h;
	coeff_rows_t      coeff_q;
	logic             queue_full, job_push, job_valid, job_pop;
	job_t             push_job, head_job;
	logic             wr_en, rd_en;
	logic [ST_AW-1:0] wr_addr, rd_addr;
	logic [7:0]       wr_data, rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DIM_W'(256);
			height_q   <= DIM_W'(256);
			coeff_q[0] <= ROW_RESET_LO;
			coeff_q[1] <= ROW_RESET_LO;
			coeff_q[2] <= ROW_RESET_LO;
			coeff_q[3] <= ROW_RESET_HI;
			coeff_q[4] <= ROW_RESET_HI;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WIDTH:  width_q    <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q   <= cfg_data[DIM_W-1:0];
				REG_ROW0:   coeff_q[0] <= cfg_data;
				REG_ROW1:   coeff_q[1] <= cfg_data;
				REG_ROW2:   coeff_q[2] <= cfg_data;
				REG_ROW3:   coeff_q[3] <= cfg_data;
				REG_ROW4:   coeff_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped frame size
	assign eff_w = (width_q == '0) ? DIM_W'(1) :
		(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign eff_h = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

	ikc_front #(.KSIZE(KSIZE)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .pixel_in,
		.img_w(eff_w), .img_h(eff_h), .queue_full,
		.wr_en, .wr_addr, .wr_data, .job_push, .job(push_job)
	);

	ikc_fifo u_fifo (
		.clk, .arst_n, .push(job_push), .push_job, .full(queue_full),
		.pop(job_pop), .head_valid(job_valid), .head_job
	);

	ikc_store u_store (
		.clk, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data
	);

	ikc_back #(.KSIZE(KSIZE)) u_back (
		.clk, .arst_n, .job_valid, .job(head_job), .job_pop,
		.coeffs(coeff_q), .img_w(eff_w), .rd_en, .rd_addr, .rd_data,
		.out_valid, .out_ready, .out_row, .out_col, .pixel_out, .border_pass, .frame_last
	);
endmodule
`default_nettype wire

>>> hdl/ikc_fifo.sv
// short job queue between the front and the back
`default_nettype none
module ikc_fifo
	import ikc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);
	localparam int PW = $clog2(FIFO_DEPTH);

	job_t            mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;
	logic            do_push, do_pop;

	assign full       = count_q == (PW+1)'(FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(FIFO_DEPTH)) else $error("job queue count out of range");
	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
		else $error("job queue count did not step on pop");
endmodule
`default_nettype wire

>>> hdl/ikc_store.sv
// pixel history memory, one write and one registered read per cycle
`default_nettype none
module ikc_store
	import ikc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [ST_AW-1:0] wr_addr,
	input  wire logic [7:0]       wr_data,
	input  wire logic             rd_en,
	input  wire logic [ST_AW-1:0] rd_addr,
	output logic      [7:0]       rd_data
);
	logic [7:0] mem [2**ST_AW];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> hdl/ikc_front.sv
// front end: takes words, writes history, decides which position is emitted
`default_nettype none
module ikc_front
	import ikc_pkg::*;
#(
	parameter int KSIZE = KSIZE_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             cmd,
	input  wire logic [7:0]       pixel_in,
	input  wire logic [DIM_W-1:0] img_w,
	input  wire logic [DIM_W-1:0] img_h,
	input  wire logic             queue_full,
	output logic                  wr_en,
	output logic      [ST_AW-1:0] wr_addr,
	output logic      [7:0]       wr_data,
	output logic                  job_push,
	output job_t                  job
);
	localparam int HALF  = KSIZE / 2;
	localparam int LAG_W = DIM_W + 1;

	logic [ST_AW-1:0] wp_q;
	logic [LAG_W-1:0] pend_q;
	logic [CNT_W-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic [LAG_W-1:0] lag;
	logic             take, is_pix, emit;

	assign in_ready = !queue_full;
	assign take     = in_valid && in_ready;
	assign is_pix   = take && !cmd;
	assign lag      = LAG_W'(img_w) * LAG_W'(HALF) + LAG_W'(HALF);

	// emit when the output lag is covered, or flush on a drain word once the input has wrapped to a frame start
	always_comb begin
		emit = 1'b0;
		if (take) begin
			if (!cmd) emit = pend_q >= lag;
			else emit = pend_q != '0 && in_row_q == '0 && in_col_q == '0;
		end
	end

	assign wr_en    = is_pix;
	assign wr_addr  = wp_q;
	assign wr_data  = pixel_in;
	assign job_push = emit;

	// job contents for the position leaving next
	always_comb begin
		job.pos   = wp_q - ST_AW'(pend_q);
		job.row   = out_row_q;
		job.col   = out_col_q;
		job.geo   = (out_row_q >= CNT_W'(HALF)) &&
			(DIM_W'(out_row_q) + DIM_W'(HALF) < img_h) &&
			(out_col_q >= CNT_W'(HALF)) &&
			(DIM_W'(out_col_q) + DIM_W'(HALF) < img_w);
		job.last  = (DIM_W'(out_row_q) == img_h - 1'b1) &&
			(DIM_W'(out_col_q) == img_w - 1'b1);
		job.latch = out_row_q == '0 && out_col_q == '0;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			pend_q    <= '0;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			if (is_pix) begin
				wp_q <= wp_q + 1'b1;
				if (DIM_W'(in_col_q) + 1'b1 >= img_w) begin
					in_col_q <= '0;
					in_row_q <= (DIM_W'(in_row_q) + 1'b1 >= img_h) ? '0 : in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (is_pix && !emit) pend_q <= pend_q + 1'b1;
			else if (!is_pix && emit) pend_q <= pend_q - 1'b1;
			if (emit) begin
				if (DIM_W'(out_col_q) + 1'b1 >= img_w) begin
					out_col_q <= '0;
					out_row_q <= (DIM_W'(out_row_q) + 1'b1 >= img_h) ? '0 : out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/ikc_back.sv
// back end: scale latch, tap accumulation, division, border pass-through and result register
`default_nettype none
module ikc_back
	import ikc_pkg::*;
#(
	parameter int KSIZE = KSIZE_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	input  job_t                  job,
	output logic                  job_pop,
	input  coeff_rows_t           coeffs,
	input  wire logic [DIM_W-1:0] img_w,
	output logic                  rd_en,
	output logic      [ST_AW-1:0] rd_addr,
	input  wire logic [7:0]       rd_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [CNT_W-1:0] out_row,
	output logic      [CNT_W-1:0] out_col,
	output logic      [7:0]       pixel_out,
	output logic                  border_pass,
	output logic                  frame_last
);
	localparam int HALF  = KSIZE / 2;
	localparam int SUM_W = $clog2(KSIZE*KSIZE*255*128+1) + 1;
	localparam int DC_W  = $clog2(SUM_W+1);
	localparam int PS_W  = $clog2(KSIZE*KSIZE*128+1);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SCALE = 11'b000_0000_0010,
		ST_SETSC = 11'b000_0000_0100,
		ST_START = 11'b000_0000_1000,
		ST_TAP   = 11'b000_0001_0000,
		ST_DRAIN = 11'b000_0010_0000,
		ST_DIV   = 11'b000_0100_0000,
		ST_FIN   = 11'b000_1000_0000,
		ST_PIX   = 11'b001_0000_0000,
		ST_PIXW  = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	state_t                   state_q;
	job_t                     job_q;
	logic [2:0]               u_q, v_q;
	logic [PS_W-1:0]          pos_acc_q, neg_acc_q;
	logic                     neg_any_q;
	logic [15:0]              scale_q;
	logic [7:0]               offset_q;
	logic [ST_AW-1:0]         tap_addr_q, row_base_q;
	logic                     vld_s1, vld_s2;
	logic signed [7:0]        coef_s1;
	logic signed [16:0]       prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]         mag_q;
	logic                     neg_q;
	logic [16:0]              rem_q;
	logic [DC_W-1:0]          dcnt_q;
	logic [7:0]               res_q;
	logic                     bord_q;
	logic signed [7:0]        k_cur;
	logic                     last_tap;
	logic [16:0]              shifted;
	logic [ST_AW-1:0]         w_ext, start_addr;
	logic [PS_W-1:0]          big;
	logic [SUM_W-1:0]         q_signed;

	assign k_cur      = coef(coeffs, u_q, v_q);
	assign last_tap   = u_q == 3'(KSIZE-1) && v_q == 3'(KSIZE-1);
	assign shifted    = {rem_q[15:0], mag_q[SUM_W-1]};
	assign w_ext      = ST_AW'(img_w);
	assign start_addr = job_q.pos - w_ext * ST_AW'(HALF) - ST_AW'(HALF);
	assign big        = (pos_acc_q > neg_acc_q) ? pos_acc_q : neg_acc_q;
	assign q_signed   = neg_q ? (~mag_q + 1'b1) : mag_q;

	assign job_pop     = state_q == ST_IDLE && job_valid;
	assign rd_en       = state_q == ST_TAP || state_q == ST_PIX;
	assign rd_addr     = (state_q == ST_PIX) ? job_q.pos : tap_addr_q;
	assign out_valid   = state_q == ST_OUT;
	assign out_row     = job_q.row;
	assign out_col     = job_q.col;
	assign pixel_out   = res_q;
	assign border_pass = bord_q;
	assign frame_last  = job_q.last;

	// product stage after the memory read
	always_ff @(posedge clk) begin
		coef_s1 <= k_cur;
		prod_s2 <= $signed({1'b0, rd_data}) * coef_s1;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			scale_q   <= '0;
			offset_q  <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			u_q       <= '0;
			v_q       <= '0;
			dcnt_q    <= '0;
		end else begin
			vld_s1 <= 1'b0;
			vld_s2 <= vld_s1;
			if (vld_s2) acc_q <= acc_q + SUM_W'(prod_s2);
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q     <= job;
						u_q       <= '0;
						v_q       <= '0;
						pos_acc_q <= '0;
						neg_acc_q <= '0;
						neg_any_q <= 1'b0;
						state_q   <= job.latch ? ST_SCALE : ST_START;
					end
				end
				// coefficient sums, one coefficient a cycle
				ST_SCALE: begin
					if (k_cur[7]) begin
						neg_acc_q <= neg_acc_q + PS_W'(-$signed({k_cur[7], k_cur}));
						neg_any_q <= 1'b1;
					end else begin
						pos_acc_q <= pos_acc_q + PS_W'(k_cur);
					end
					if (v_q == 3'(KSIZE-1)) begin
						v_q <= '0;
						u_q <= u_q + 1'b1;
					end else begin
						v_q <= v_q + 1'b1;
					end
					if (last_tap) state_q <= ST_SETSC;
				end
				ST_SETSC: begin
					if (!neg_any_q) begin
						scale_q  <= 16'(pos_acc_q);
						offset_q <= 8'd0;
					end else begin
						scale_q  <= 16'({big, 1'b0});
						offset_q <= 8'd128;
					end
					state_q <= ST_START;
				end
				ST_START: begin
					u_q        <= '0;
					v_q        <= '0;
					acc_q      <= '0;
					tap_addr_q <= start_addr;
					row_base_q <= start_addr;
					state_q    <= (job_q.geo && scale_q != '0) ? ST_TAP : ST_PIX;
				end
				// one tap read a cycle
				ST_TAP: begin
					vld_s1 <= 1'b1;
					if (v_q == 3'(KSIZE-1)) begin
						v_q        <= '0;
						u_q        <= u_q + 1'b1;
						row_base_q <= row_base_q + w_ext;
						tap_addr_q <= row_base_q + w_ext;
					end else begin
						v_q        <= v_q + 1'b1;
						tap_addr_q <= tap_addr_q + 1'b1;
					end
					if (last_tap) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						neg_q   <= acc_q[SUM_W-1];
						mag_q   <= acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
						rem_q   <= '0;
						dcnt_q  <= DC_W'(SUM_W);
						state_q <= ST_DIV;
					end
				end
				// restoring division, one quotient bit a cycle
				ST_DIV: begin
					if (shifted >= {1'b0, scale_q}) begin
						rem_q <= shifted - {1'b0, scale_q};
						mag_q <= {mag_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= shifted;
						mag_q <= {mag_q[SUM_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DC_W'(1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					res_q   <= q_signed[7:0] + offset_q;
					bord_q  <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_PIX: state_q <= ST_PIXW;
				ST_PIXW: begin
					res_q   <= rd_data;
					bord_q  <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_after_taps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !vld_s1 && !vld_s2) else $error("taps pending in division");
	a_s2_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1)) else $error("product stage without read");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && !out_ready |=> state_q == ST_OUT)
		else $error("result dropped before accept");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> state_q != ST_IDLE) else $error("job taken but back stayed idle");
endmodule
`default_nettype wire

>>> tb/ikc_checker.sv
// watches the convolution block's ports, predicts every output word and compares
`default_nettype none
module ikc_checker
	import ikc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic              cmd,
	input  wire logic [7:0]        pixel_in,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic [CNT_W-1:0]  out_row,
	input  wire logic [CNT_W-1:0]  out_col,
	input  wire logic [7:0]        pixel_out,
	input  wire logic              border_pass,
	input  wire logic              frame_last,
	output int                     errors,
	output int                     outstanding
);

	localparam int HALF = 2;
	localparam int KN   = 5;

	typedef struct {
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		logic [7:0]       pix;
		logic             bp;
		logic             last;
	} pixel_word_t;

	// shadow registers
	logic [DIM_W-1:0]  width_r, height_r;
	logic [CFG_DW-1:0] krow [KN];

	// model state
	logic [7:0]  hist [8192];
	int unsigned in_r, in_c, o_r, o_c, wr_pos, pend;
	int unsigned scale_v, offset_v;

	pixel_word_t pending_q [$];

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d);
		if (d < 1) return 1;
		if (d > 1024) return 1024;
		return d;
	endfunction

	function automatic int kcoef(input int u, input int v);
		logic [7:0] b;
		b = krow[u][8*v +: 8];
		return int'($signed(b));
	endfunction

	task automatic step_pos(inout int unsigned r, inout int unsigned c,
			input int unsigned w, input int unsigned h);
		if (c + 1 >= w) begin
			c = 0;
			r = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			c = c + 1;
		end
	endtask

	// pick scale and offset from the current kernel
	task automatic latch_scale();
		int total, pos_s, neg_s, k;
		bit lowpass;
		total = 0; pos_s = 0; neg_s = 0; lowpass = 1'b1;
		for (int u = 0; u < KN; u++) begin
			for (int v = 0; v < KN; v++) begin
				k = kcoef(u, v);
				total += k;
				if (k > 0) pos_s += k;
				if (k < 0) begin
					neg_s -= k;
					lowpass = 1'b0;
				end
			end
		end
		if (lowpass) begin
			scale_v = total & 16'hffff;
			offset_v = 0;
		end else begin
			scale_v = (2 * (pos_s > neg_s ? pos_s : neg_s)) & 16'hffff;
			offset_v = 128;
		end
	endtask

	// advance the model by one accepted input word
	task automatic predict_word(input logic c_in, input logic [7:0] p_in);
		int unsigned w, h, lag, pos, r, c;
		bit fire;
		int sum, q, tap;
		logic [31:0] idx;
		logic [7:0] val;
		pixel_word_t e;
		w = clamp_dim(width_r);
		h = clamp_dim(height_r);
		lag = HALF * w + HALF;
		if (!c_in) begin
			hist[wr_pos[12:0]] = p_in;
			wr_pos++;
			pend++;
			step_pos(in_r, in_c, w, h);
			fire = pend > lag;
		end else begin
			fire = pend > 0 && in_r == 0 && in_c == 0;
		end
		if (fire) begin
			pos = wr_pos - pend;
			pend--;
			r = o_r;
			c = o_c;
			if (r == 0 && c == 0) latch_scale();
			val = hist[pos[12:0]];
			e.bp = 1'b1;
			if (int'(r) >= HALF && int'(r) < int'(h) - HALF &&
					int'(c) >= HALF && int'(c) < int'(w) - HALF && scale_v != 0) begin
				sum = 0;
				for (int u = 0; u < KN; u++) begin
					for (int v = 0; v < KN; v++) begin
						tap = (u - HALF) * int'(w) + (v - HALF);
						idx = pos + tap;
						sum += int'(hist[idx[12:0]]) * kcoef(u, v);
					end
				end
				q = sum / int'(scale_v);
				val = q[7:0] + offset_v[7:0];
				e.bp = 1'b0;
			end
			e.row = r[CNT_W-1:0];
			e.col = c[CNT_W-1:0];
			e.pix = val;
			e.last = (r == h - 1 && c == w - 1);
			pending_q.push_back(e);
			step_pos(o_r, o_c, w, h);
		end
	endtask

	// config shadow, prediction and compare
	always @(posedge clk or negedge arst_n) begin
		pixel_word_t e;
		if (!arst_n) begin
			width_r = DIM_W'(256);
			height_r = DIM_W'(256);
			krow[0] = ROW_RESET_LO;
			krow[1] = ROW_RESET_LO;
			krow[2] = ROW_RESET_LO;
			krow[3] = ROW_RESET_HI;
			krow[4] = ROW_RESET_HI;
			in_r = 0; in_c = 0; o_r = 0; o_c = 0;
			wr_pos = 0; pend = 0; scale_v = 0; offset_v = 0;
			pending_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_WIDTH: width_r = cfg_data[DIM_W-1:0];
					REG_HEIGHT: height_r = cfg_data[DIM_W-1:0];
					REG_ROW0: krow[0] = cfg_data;
					REG_ROW1: krow[1] = cfg_data;
					REG_ROW2: krow[2] = cfg_data;
					REG_ROW3: krow[3] = cfg_data;
					REG_ROW4: krow[4] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_word(cmd, pixel_in);
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected word row %0d col %0d pix %0d", $time,
						out_row, out_col, pixel_out);
					errors++;
				end else begin
					e = pending_q.pop_front();
					if (out_row !== e.row) begin
						$display("%0t: out_row exp %0d got %0d", $time, e.row, out_row);
						errors++;
					end
					if (out_col !== e.col) begin
						$display("%0t: out_col exp %0d got %0d", $time, e.col, out_col);
						errors++;
					end
					if (pixel_out !== e.pix) begin
						$display("%0t: pixel_out (%0d,%0d) exp %0d got %0d", $time,
							e.row, e.col, e.pix, pixel_out);
						errors++;
					end
					if (border_pass !== e.bp) begin
						$display("%0t: border_pass exp %0d got %0d", $time, e.bp, border_pass);
						errors++;
					end
					if (frame_last !== e.last) begin
						$display("%0t: frame_last exp %0d got %0d", $time, e.last, frame_last);
						errors++;
					end
				end
			end
		end
		outstanding = pending_q.size();
	end

endmodule
`default_nettype wire

>>> tb/tb.sv
// stimulus and verdict for the integer kernel image convolution block
`default_nettype none
module tb;
	import ikc_pkg::*;

	localparam int LIMIT = 3000000;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_we = 0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic              in_valid = 0;
	logic              in_ready;
	logic              cmd = 0;
	logic [7:0]        pixel_in = '0;
	logic              out_valid;
	logic              out_ready = 0;
	logic [CNT_W-1:0]  out_row, out_col;
	logic [7:0]        pixel_out;
	logic              border_pass, frame_last;
	int                errors, outstanding;

	int unsigned cyc = 0;
	int          hold_left = 0;
	bit          quiet = 0;
	int unsigned cur_w, cur_h;
	int          rand_pixels = 0;

	integer_kernel_image_convolution_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.pixel_in(pixel_in), .out_valid(out_valid), .out_ready(out_ready),
		.out_row(out_row), .out_col(out_col), .pixel_out(pixel_out),
		.border_pass(border_pass), .frame_last(frame_last)
	);

	ikc_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.pixel_in(pixel_in), .out_valid(out_valid), .out_ready(out_ready),
		.out_row(out_row), .out_col(out_col), .pixel_out(pixel_out),
		.border_pass(border_pass), .frame_last(frame_last),
		.errors(errors), .outstanding(outstanding)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// output side: random stalls plus the long hold-off
	initial begin
		int stall_left, run_left;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 0;
				stall_left--;
			end else if (run_left > 0) begin
				out_ready <= 1;
				run_left--;
			end else begin
				out_ready <= 1;
				stall_left = gap_len();
				run_left = $urandom_range(0, 12);
			end
		end
	end

	// offer one word and hold it until accepted
	task automatic send_word(input logic c, input logic [7:0] p);
		int g;
		bit acc;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		pixel_in <= p;
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
	endtask

	// wait for every expected word, then let the back end settle
	task automatic wait_idle();
		in_valid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
		cfg_we <= 1;
		cfg_addr <= a;
		cfg_data <= d;
		@(posedge clk);
	endtask

	function automatic int unsigned clamp_dim(input int unsigned d);
		d = d & 11'h7ff;
		if (d < 1) return 1;
		if (d > 1024) return 1024;
		return d;
	endfunction

	task automatic set_size(input int unsigned w, input int unsigned h);
		write_reg(REG_WIDTH, CFG_DW'(w));
		write_reg(REG_HEIGHT, CFG_DW'(h));
		cfg_we <= 0;
		cur_w = clamp_dim(w);
		cur_h = clamp_dim(h);
	endtask

	task automatic set_kernel(input logic [CFG_DW-1:0] r0, input logic [CFG_DW-1:0] r1,
			input logic [CFG_DW-1:0] r2, input logic [CFG_DW-1:0] r3,
			input logic [CFG_DW-1:0] r4);
		write_reg(REG_ROW0, r0);
		write_reg(REG_ROW1, r1);
		write_reg(REG_ROW2, r2);
		write_reg(REG_ROW3, r3);
		write_reg(REG_ROW4, r4);
		cfg_we <= 0;
	endtask

	// one kernel row: random, small positive, or sparse signed
	function automatic logic [CFG_DW-1:0] rand_row(input int mode);
		logic [CFG_DW-1:0] r;
		for (int v = 0; v < 5; v++) begin
			case (mode)
				0: r[8*v +: 8] = 8'($urandom_range(0, 255));
				1: r[8*v +: 8] = 8'($urandom_range(0, 20));
				default: r[8*v +: 8] = ($urandom_range(0, 2) == 0) ?
					8'($urandom_range(0, 255)) : 8'h00;
			endcase
		end
		return r;
	endfunction

	// one full frame: pixels with stray drain words, then the flush
	task automatic run_frame(input int pmode, input bit counted);
		logic [7:0] p;
		for (int i = 0; i < cur_w * cur_h; i++) begin
			case (pmode)
				1: p = 8'h00;
				2: p = 8'hff;
				3: p = i[0] ? 8'hff : 8'h00;
				default: p = 8'($urandom_range(0, 255));
			endcase
			if ($urandom_range(0, 19) == 0) send_word(1'b1, 8'($urandom_range(0, 255)));
			send_word(1'b0, p);
			if (counted) rand_pixels++;
		end
		repeat (2 * cur_w + 2 + $urandom_range(0, 3))
			send_word(1'b1, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int m;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: reset kernel, signed extremes, zero kernel, size clamp
		set_size(5, 5);
		run_frame(2, 0);
		wait_idle();
		set_kernel(40'h80_8080_8080, 40'h80_8080_8080, 40'h80_8080_8080,
			40'h80_8080_8080, 40'h80_8080_8080);
		run_frame(3, 0);
		wait_idle();
		set_kernel(40'h7f_7f7f_7f7f, 40'h7f_7f7f_7f7f, 40'h7f_7f7f_7f7f,
			40'h7f_7f7f_7f7f, 40'h7f_7f7f_7f7f);
		run_frame(2, 0);
		run_frame(1, 0);
		wait_idle();
		set_kernel(40'h0, 40'h0, 40'h0, 40'h0, 40'h0);
		run_frame(0, 0);
		wait_idle();
		set_kernel(40'hff_ffff_ffff, 40'h01_0203_0405, 40'h7f_8000_7f80, 40'h0,
			40'hff_ffff_ffff);
		set_size(0, 0);
		run_frame(0, 0);
		wait_idle();

		// long output hold-off on a wide frame so the input backs up
		set_size(40, 6);
		set_kernel(rand_row(0), rand_row(0), rand_row(0), rand_row(0), rand_row(0));
		hold_left = 600;
		run_frame(0, 0);
		wait_idle();

		// random phases
		while (rand_pixels < 80) begin
			quiet = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) == 0) set_size($urandom_range(11, 40), $urandom_range(1, 3));
			else set_size($urandom_range(1, 10), $urandom_range(1, 10));
			m = $urandom_range(0, 3);
			if (m == 3) set_kernel(ROW_RESET_LO, ROW_RESET_LO, ROW_RESET_LO, 40'h0, 40'h0);
			else set_kernel(rand_row(m), rand_row(m), rand_row(m), rand_row(m), rand_row(m));
			repeat ($urandom_range(1, 2)) run_frame(($urandom_range(0, 7) == 0) ? 3 : 0, 1);
			wait_idle();
		end
		quiet = 0;

		while (outstanding != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
